// File: hw/rtl/gclp_pkg.sv
// gclp_pkg: shared constants, types and helper functions of the G-code line parser.
// No dependencies; imported by gclp_value_unit, gcode_line_parser_core and the testbench.
`default_nettype none

package gclp_pkg;

	localparam int FRAC_DIGITS = 4;
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int NUM_SLOTS   = 6;
	localparam int SLOT_W      = 3;
	localparam int FLAGS_W     = NUM_SLOTS + 1;
	localparam int PLACE_W     = $clog2(FRAC_DIGITS + 1);
	localparam int WIDX_W      = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
	// room for 9 * 10^FRAC_DIGITS (below 2^24) on top of a full value
	localparam int ACC_W       = VALUE_WIDTH + 25;

	localparam logic [SLOT_W-1:0] SLOT_X       = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_Y       = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_Z       = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_F       = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_S       = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_P       = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_UNKNOWN = 3'd6;

	localparam logic [1:0] LTR_NONE = 2'd0;
	localparam logic [1:0] LTR_G    = 2'd1;
	localparam logic [1:0] LTR_M    = 2'd2;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_P     = 8'h50;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	// per-item control into the value unit
	typedef struct packed {
		logic [3:0]         digit;
		logic [PLACE_W-1:0] place;
	} vctl_t;

	function automatic longint pow10(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] c);
		logic [SLOT_W-1:0] s;
		unique case (c)
			CH_X:    s = SLOT_X;
			CH_Y:    s = SLOT_Y;
			CH_Z:    s = SLOT_Z;
			CH_F:    s = SLOT_F;
			CH_S:    s = SLOT_S;
			CH_P:    s = SLOT_P;
			default: s = SLOT_UNKNOWN;
		endcase
		return s;
	endfunction

	// stored value to the 32-bit result field: sign-extend or keep low bits
	function automatic logic [OUT_WIDTH-1:0] out_bits(input value_t v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[OUT_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gclp_value_unit.sv
// gclp_value_unit: saturating fixed-point digit accumulate and negate for one value.
// Depends on gclp_pkg.
`default_nettype none

module gclp_value_unit (
	input  wire gclp_pkg::value_t cur_value,
	input  wire gclp_pkg::vctl_t  ctl,
	output gclp_pkg::value_t      int_value,
	output gclp_pkg::value_t      frac_value,
	output gclp_pkg::value_t      neg_value
);
	import gclp_pkg::*;

	typedef logic [FRAC_DIGITS-1:0][ACC_W-1:0] wtab_t;

	function automatic wtab_t make_wtab();
		wtab_t t;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			t[i] = ACC_W'(pow10(FRAC_DIGITS - 1 - i));
		end
		return t;
	endfunction

	localparam wtab_t FRAC_WEIGHT = make_wtab();
	localparam logic [ACC_W-1:0] INT_WEIGHT = ACC_W'(pow10(FRAC_DIGITS));

	localparam logic signed [ACC_W-1:0] VMAX_A =
		{{(ACC_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] VMIN_A =
		{{(ACC_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
	localparam value_t VMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

	logic signed [ACC_W-1:0] v_ext;
	logic signed [ACC_W-1:0] times10;
	logic signed [ACC_W-1:0] times10_sat;
	logic signed [ACC_W-1:0] int_add;
	logic signed [ACC_W-1:0] frac_add;
	logic signed [ACC_W-1:0] int_sum;
	logic signed [ACC_W-1:0] frac_sum;

	assign v_ext   = ACC_W'(cur_value);
	assign times10 = (v_ext <<< 3) + (v_ext <<< 1);

	always_comb begin
		if (times10 > VMAX_A) begin
			times10_sat = VMAX_A;
		end else if (times10 < VMIN_A) begin
			times10_sat = VMIN_A;
		end else begin
			times10_sat = times10;
		end
	end

	assign int_add  = ACC_W'(ctl.digit) * INT_WEIGHT;
	assign frac_add = ACC_W'(ctl.digit) * FRAC_WEIGHT[ctl.place[WIDX_W-1:0]];
	assign int_sum  = times10_sat + int_add;
	assign frac_sum = v_ext + frac_add;

	// addends are never negative, so only the upper bound can be crossed
	assign int_value  = (int_sum > VMAX_A) ? VMAX : int_sum[VALUE_WIDTH-1:0];
	assign frac_value = (frac_sum > VMAX_A) ? VMAX : frac_sum[VALUE_WIDTH-1:0];
	assign neg_value  = (cur_value == VMIN) ? VMAX : -cur_value;

endmodule

`default_nettype wire

// File: hw/rtl/gcode_line_parser_core.sv
// gcode_line_parser_core: top level of the G-code line parser.
// Depends on gclp_pkg and gclp_value_unit.
//
// Input channel: one ASCII byte per item on char_in, handshake in_valid/in_stall.
// Output channel: one result item per CR or LF byte, handshake out_valid/out_stall,
// carrying command letter and number, the six values X Y Z F S P, presence
// flags and the bad-line mark.
// An accepted byte lands in an input register; from there it updates the
// parser state, and a line end loads the result register.
// Throughput: one byte per cycle, sustained. The only limit is the result
// register: a line-end byte waits in the input register while an earlier result
// is still held by out_stall, and in_stall then rises. Other bytes keep flowing
// while a result waits, as long as no second line end arrives.
// Reset (arst_n low, asynchronous) clears the parser to "waiting for G or M",
// zeroes all values and flags, and empties both registers.
// Each line end also clears the parser for the next line.
`default_nettype none

module gcode_line_parser_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire  [7:0]                  char_in,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [1:0]                  cmd_letter,
	output logic [15:0]                 cmd_number,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_x,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_y,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_z,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_f,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_s,
	output logic [gclp_pkg::OUT_WIDTH-1:0] value_p,
	output logic [gclp_pkg::FLAGS_W-1:0]   present_flags,
	output logic                        bad_line
);
	import gclp_pkg::*;

	typedef enum logic [2:0] {
		MODE_CMD,
		MODE_CMDNUM,
		MODE_FIRST,
		MODE_INT,
		MODE_FRAC,
		MODE_LETTER,
		MODE_COMMENT,
		MODE_BAD
	} mode_t;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;

	// parser state
	mode_t               mode_q,   mode_d;
	logic [1:0]          letter_q, letter_d;
	logic [15:0]         number_q, number_d;
	value_t              value_q [NUM_SLOTS];
	value_t              value_d [NUM_SLOTS];
	logic [FLAGS_W-1:0]  flags_q,  flags_d;
	logic [SLOT_W-1:0]   slot_q,   slot_d;
	logic                neg_q,    neg_d;
	logic [PLACE_W-1:0]  place_q,  place_d;

	// result register
	logic                out_valid_q;
	logic [1:0]          res_letter_q;
	logic [15:0]         res_number_q;
	logic [OUT_WIDTH-1:0] res_value_q [NUM_SLOTS];
	logic [FLAGS_W-1:0]  res_flags_q;
	logic                res_bad_q;
	logic [OUT_WIDTH-1:0] res_value_d [NUM_SLOTS];

	logic   is_eol;
	logic   advance;
	logic   work;
	logic   emit;
	value_t sel_value;
	vctl_t  vctl;
	value_t int_value;
	value_t frac_value;
	value_t neg_value;
	logic [19:0] number_next;

	assign is_eol   = (char_s1 == CH_LF) || (char_s1 == CH_CR);
	// only a line end needs the result register
	assign advance  = !(is_eol && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign work     = valid_s1 && advance;
	assign emit     = work && is_eol;

	always_comb begin
		sel_value = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_q == SLOT_W'(i)) begin
				sel_value = value_q[i];
			end
		end
	end

	assign vctl.digit = char_s1[3:0];
	assign vctl.place = place_q;

	gclp_value_unit u_value (
		.cur_value (sel_value),
		.ctl       (vctl),
		.int_value (int_value),
		.frac_value(frac_value),
		.neg_value (neg_value)
	);

	assign number_next = 20'(number_q) * 20'd10 + 20'(char_s1[3:0]);

	// result values with the pending minus sign of the open value applied
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (neg_q && slot_q == SLOT_W'(i)) begin
				res_value_d[i] = out_bits(neg_value);
			end else begin
				res_value_d[i] = out_bits(value_q[i]);
			end
		end
	end

	always_comb begin
		logic  done;
		logic  end_val;
		mode_t m;
		done     = 1'b0;
		end_val  = 1'b0;
		m        = mode_q;
		mode_d   = mode_q;
		letter_d = letter_q;
		number_d = number_q;
		flags_d  = flags_q;
		slot_d   = slot_q;
		neg_d    = neg_q;
		place_d  = place_q;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			value_d[i] = value_q[i];
		end

		if (emit) begin
			mode_d   = MODE_CMD;
			letter_d = LTR_NONE;
			number_d = '0;
			flags_d  = '0;
			slot_d   = SLOT_X;
			neg_d    = 1'b0;
			place_d  = '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				value_d[i] = '0;
			end
		end else if (work && char_s1 != CH_SPACE && char_s1 != CH_TAB) begin
			if (char_s1 == CH_SEMI) begin
				m = MODE_COMMENT;
			end
			if (m == MODE_CMD) begin
				if (char_s1 == CH_G || char_s1 == CH_M) begin
					letter_d = (char_s1 == CH_G) ? LTR_G : LTR_M;
					number_d = '0;
					m        = MODE_CMDNUM;
				end else begin
					m = MODE_BAD;
				end
				done = 1'b1;
			end
			if (!done && m == MODE_CMDNUM) begin
				if (is_digit(char_s1)) begin
					number_d = (number_next > 20'd65535) ? 16'hFFFF : number_next[15:0];
					done     = 1'b1;
				end else begin
					m = MODE_LETTER;
				end
			end
			if (!done && m == MODE_FIRST) begin
				m = MODE_INT;
				if (char_s1 == CH_MINUS) begin
					neg_d = 1'b1;
					done  = 1'b1;
				end
			end
			if (!done && m == MODE_INT) begin
				if (char_s1 == CH_DOT) begin
					m    = MODE_FRAC;
					done = 1'b1;
				end else if (is_digit(char_s1)) begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slot_q == SLOT_W'(i)) begin
							value_d[i] = int_value;
						end
					end
					done = 1'b1;
				end else begin
					end_val = 1'b1;
					m       = MODE_LETTER;
				end
			end
			if (!done && m == MODE_FRAC) begin
				if (is_digit(char_s1)) begin
					if (place_q < PLACE_W'(FRAC_DIGITS)) begin
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (slot_q == SLOT_W'(i)) begin
								value_d[i] = frac_value;
							end
						end
						place_d = place_q + 1'b1;
					end
					done = 1'b1;
				end else begin
					end_val = 1'b1;
					m       = MODE_LETTER;
				end
			end
			if (end_val) begin
				if (neg_q) begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slot_q == SLOT_W'(i)) begin
							value_d[i] = neg_value;
						end
					end
				end
				neg_d   = 1'b0;
				place_d = '0;
			end
			if (!done && m == MODE_LETTER) begin
				slot_d  = slot_of(char_s1);
				flags_d = flags_q | (FLAGS_W'(1) << slot_of(char_s1));
				m       = (slot_of(char_s1) == SLOT_UNKNOWN) ? MODE_BAD : MODE_FIRST;
			end
			mode_d = m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CMD;
			letter_q <= LTR_NONE;
			number_q <= '0;
			flags_q  <= '0;
			slot_q   <= SLOT_X;
			neg_q    <= 1'b0;
			place_q  <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				value_q[i] <= '0;
			end
		end else begin
			mode_q   <= mode_d;
			letter_q <= letter_d;
			number_q <= number_d;
			flags_q  <= flags_d;
			slot_q   <= slot_d;
			neg_q    <= neg_d;
			place_q  <= place_d;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				value_q[i] <= value_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_letter_q <= letter_q;
			res_number_q <= number_q;
			res_flags_q  <= flags_q;
			res_bad_q    <= (mode_q == MODE_BAD);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				res_value_q[i] <= res_value_d[i];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cmd_letter    = res_letter_q;
	assign cmd_number    = res_number_q;
	assign value_x       = res_value_q[SLOT_X];
	assign value_y       = res_value_q[SLOT_Y];
	assign value_z       = res_value_q[SLOT_Z];
	assign value_f       = res_value_q[SLOT_F];
	assign value_s       = res_value_q[SLOT_S];
	assign value_p       = res_value_q[SLOT_P];
	assign present_flags = res_flags_q;
	assign bad_line      = res_bad_q;

	// a line end always leaves a clean parser behind
	a_clear_after_eol: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (mode_q == MODE_CMD && flags_q == '0 && !neg_q && letter_q == LTR_NONE))
		else $error("parser state not cleared after line end");

	// back-pressure only comes from a waiting line end
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_eol && out_valid_q && out_stall))
		else $error("input stalled without a blocked line end");

	// a line end loads the result register
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("line end did not produce a result");

	// while a value is open its slot is a known letter
	a_slot_known: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FIRST || mode_q == MODE_INT || mode_q == MODE_FRAC)
		|-> (slot_q < SLOT_UNKNOWN))
		else $error("value parsing with unknown slot");

	// a pending minus sign only lives inside an open value or a comment after it
	a_neg_scope: assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> (mode_q == MODE_INT || mode_q == MODE_FRAC || mode_q == MODE_COMMENT))
		else $error("minus sign pending outside a value");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench: self-checking bench for gcode_line_parser_core, one ASCII byte per input item.
// Depends on gclp_pkg for character codes, slot and letter codes and field widths.
// A scoreboard class predicts each line result; directed lines run first, then random ones.

module testbench;

	import gclp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 700;
	localparam int QUIET_TAIL   = 150;

	typedef enum logic [2:0] {
		PM_CMD, PM_CMDNUM, PM_FIRST, PM_INT, PM_FRAC, PM_LETTER, PM_COMMENT, PM_BAD
	} parse_mode_t;

	typedef struct packed {
		logic [1:0]                           letter;
		logic [15:0]                          number;
		logic [NUM_SLOTS-1:0][OUT_WIDTH-1:0] vals;
		logic [FLAGS_W-1:0]                   flags;
		logic                                 bad;
	} line_result_t;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic [7:0]           char_in = 8'h00;
	logic                 out_stall = 0;
	logic                 in_stall;
	logic                 out_valid;
	logic [1:0]           cmd_letter;
	logic [15:0]          cmd_number;
	logic [OUT_WIDTH-1:0] value_x, value_y, value_z, value_f, value_s, value_p;
	logic [FLAGS_W-1:0]   present_flags;
	logic                 bad_line;

	gcode_line_parser_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .char_in(char_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd_letter(cmd_letter), .cmd_number(cmd_number),
		.value_x(value_x), .value_y(value_y), .value_z(value_z),
		.value_f(value_f), .value_s(value_s), .value_p(value_p),
		.present_flags(present_flags), .bad_line(bad_line)
	);

	class line_scoreboard;
		parse_mode_t        mode;
		logic [1:0]         letter;
		int unsigned        number;
		longint             vals[NUM_SLOTS];
		logic [FLAGS_W-1:0] flags;
		int                 slot;
		bit                 neg;
		int                 place;
		line_result_t       expected_lines[$];
		int                 errors;
		int                 lines_checked;

		function new();
			errors = 0;
			lines_checked = 0;
			clear();
		endfunction

		function void clear();
			mode = PM_CMD;
			letter = LTR_NONE;
			number = 0;
			foreach (vals[i]) vals[i] = 0;
			flags = '0;
			slot = 0;
			neg = 0;
			place = 0;
		endfunction

		function longint top_value();
			return (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
		endfunction

		function longint ten_to(int n);
			longint r;
			r = 1;
			for (int i = 0; i < n; i++) r = r * 10;
			return r;
		endfunction

		function longint times_ten(longint v);
			if (v > top_value() / 10) return top_value();
			if (v < (-top_value() - 1) / 10) return -top_value() - 1;
			return v * 10;
		endfunction

		// addend is never negative, so only the upper bound matters
		function longint plus_clip(longint v, longint a);
			if (v > top_value() - a) return top_value();
			return v + a;
		endfunction

		function void close_value();
			if (neg && slot < NUM_SLOTS) begin
				if (vals[slot] == -top_value() - 1)
					vals[slot] = top_value();
				else
					vals[slot] = -vals[slot];
			end
			neg = 0;
			place = 0;
		endfunction

		function bit is_num(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function bit parse_byte(logic [7:0] c, output line_result_t r);
			int unsigned n;
			longint d;
			r = '0;
			d = longint'(c) - longint'(CH_ZERO);
			if (c == CH_LF || c == CH_CR) begin
				close_value();
				r.letter = letter;
				r.number = number[15:0];
				for (int i = 0; i < NUM_SLOTS; i++) r.vals[i] = vals[i][OUT_WIDTH-1:0];
				r.flags = flags;
				r.bad = (mode == PM_BAD);
				clear();
				return 1;
			end
			if (c == CH_SPACE || c == CH_TAB) return 0;
			if (c == CH_SEMI) mode = PM_COMMENT;
			if (mode == PM_CMD) begin
				if (c == CH_G || c == CH_M) begin
					letter = (c == CH_G) ? LTR_G : LTR_M;
					number = 0;
					mode = PM_CMDNUM;
				end else begin
					mode = PM_BAD;
				end
				return 0;
			end
			if (mode == PM_CMDNUM) begin
				if (is_num(c)) begin
					n = number * 10 + int'(d);
					number = (n > 65535) ? 65535 : n;
					return 0;
				end
				mode = PM_LETTER;
			end
			if (mode == PM_FIRST) begin
				mode = PM_INT;
				if (c == CH_MINUS) begin
					neg = 1;
					return 0;
				end
			end
			if (mode == PM_INT) begin
				if (c == CH_DOT) begin
					mode = PM_FRAC;
					return 0;
				end
				if (is_num(c)) begin
					if (slot < NUM_SLOTS)
						vals[slot] = plus_clip(times_ten(vals[slot]), d * ten_to(FRAC_DIGITS));
					return 0;
				end
				close_value();
				mode = PM_LETTER;
			end
			if (mode == PM_FRAC) begin
				if (is_num(c)) begin
					// digits past the fixed-point precision are dropped
					if (place < FRAC_DIGITS) begin
						if (slot < NUM_SLOTS)
							vals[slot] = plus_clip(vals[slot],
								d * ten_to(FRAC_DIGITS - 1 - place));
						place++;
					end
					return 0;
				end
				close_value();
				mode = PM_LETTER;
			end
			if (mode == PM_LETTER) begin
				case (c)
					CH_X:    slot = SLOT_X;
					CH_Y:    slot = SLOT_Y;
					CH_Z:    slot = SLOT_Z;
					CH_F:    slot = SLOT_F;
					CH_S:    slot = SLOT_S;
					CH_P:    slot = SLOT_P;
					default: slot = SLOT_UNKNOWN;
				endcase
				flags = flags | FLAGS_W'(1 << slot);
				mode = (slot == SLOT_UNKNOWN) ? PM_BAD : PM_FIRST;
			end
			return 0;
		endfunction

		function void note_input(logic [7:0] c);
			line_result_t r;
			if (parse_byte(c, r)) expected_lines.push_back(r);
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 100) $display("MISMATCH at result %0d: %s", lines_checked, msg);
		endtask

		task check_result(line_result_t got);
			line_result_t want;
			string names[NUM_SLOTS];
			names = '{"value_x", "value_y", "value_z", "value_f", "value_s", "value_p"};
			if (expected_lines.size() == 0) begin
				report_mismatch("result item with none expected");
				lines_checked++;
				return;
			end
			want = expected_lines.pop_front();
			if (got.letter !== want.letter)
				report_mismatch($sformatf("cmd_letter exp %0d got %0d", want.letter, got.letter));
			if (got.number !== want.number)
				report_mismatch($sformatf("cmd_number exp %0d got %0d", want.number, got.number));
			for (int i = 0; i < NUM_SLOTS; i++)
				if (got.vals[i] !== want.vals[i])
					report_mismatch($sformatf("%s exp %0d got %0d", names[i],
						$signed(want.vals[i]), $signed(got.vals[i])));
			if (got.flags !== want.flags)
				report_mismatch($sformatf("present_flags exp %b got %b", want.flags, got.flags));
			if (got.bad !== want.bad)
				report_mismatch($sformatf("bad_line exp %b got %b", want.bad, got.bad));
			lines_checked++;
		endtask
	endclass

	line_scoreboard sb;
	line_result_t   seen_line;
	int             bytes_sent = 0;
	int             directed_lines = 0;
	int             cycles = 0;
	bit             idle_on = 1;
	int             stall_left = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited", cycles, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// sample mid-cycle: what holds here is what the next rising edge accepts
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_line.letter = cmd_letter;
			seen_line.number = cmd_number;
			seen_line.vals[0] = value_x;
			seen_line.vals[1] = value_y;
			seen_line.vals[2] = value_z;
			seen_line.vals[3] = value_f;
			seen_line.vals[4] = value_s;
			seen_line.vals[5] = value_p;
			seen_line.flags = present_flags;
			seen_line.bad = bad_line;
			sb.check_result(seen_line);
		end
	end

	task automatic send_byte(input logic [7:0] c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		char_in <= c;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		sb.note_input(c);
		bytes_sent++;
		@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic hold_until_drained();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic maybe_blank();
		if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	task automatic send_digits(input int n);
		repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	function automatic logic [7:0] word_letter();
		case ($urandom_range(0, 6))
			0: return CH_X;
			1: return CH_Y;
			2: return CH_Z;
			3: return CH_F;
			4: return CH_S;
			5: return CH_P;
			default: return 8'h41 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// mostly well-formed command lines with random content, some raw noise
	task automatic random_line();
		if ($urandom_range(0, 99) < 85) begin
			maybe_blank();
			send_byte($urandom_range(0, 1) ? CH_G : CH_M);
			send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3));
			repeat ($urandom_range(0, 5)) begin
				maybe_blank();
				send_byte(word_letter());
				maybe_blank();
				if ($urandom_range(0, 3) == 0) send_byte(CH_MINUS);
				send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(8, 12)
					: $urandom_range(0, 4));
				if ($urandom_range(0, 2) == 0) begin
					send_byte(CH_DOT);
					send_digits($urandom_range(0, 6));
				end
			end
			if ($urandom_range(0, 5) == 0) begin
				send_byte(CH_SEMI);
				repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(32, 126)));
			end
		end else begin
			repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
		end
		send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
	endtask

	initial begin
		int  random_start;
		bit  pressed;
		pressed = 0;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_text("\n");
		send_text("G0\r");
		send_text("M65536\n");
		send_text("G1 X-12.5 Y3.14159 Z0.00001\n");
		send_text("G01 X214748.3647 Y-214748.3648\n");
		send_text("G1 X999999999999 F-99999999999.9999\n");
		send_text("M3 S1000 P7. ; spindle on\n");
		send_text("G1 X1 Q5 Y2\n");
		send_text("T5 X1\n");
		send_text("; only a comment\n");
		send_text("G1 X-3;X5\n");
		send_text("G1 X1 X2.5 X-4\n");
		send_text("G1 X-99999 X99999 X1\n");
		send_text("G1 X1.2.3\n");
		send_text("G1 X--5\n");
		send_text("\t G 1\t X 5 \r");
		send_text("G\n");
		send_text("G1 X\n");
		send_text("G1 -5\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\n");
		send_text("G1 X");
		send_byte(8'hFF);
		send_text("\r");
		send_text("G99999 Z0.9999 S-.5\n");
		directed_lines = sb.lines_checked + sb.pending();

		hold_until_drained();
		random_start = bytes_sent;
		while (bytes_sent < random_start + RANDOM_BYTES) begin
			if (bytes_sent >= random_start + RANDOM_BYTES - QUIET_TAIL)
				idle_on = 0;
			else
				idle_on = ($urandom_range(0, 3) != 0);
			random_line();
			if (!pressed && bytes_sent > random_start + RANDOM_BYTES / 2) begin
				hold_until_drained();
				pressed = 1;
			end
		end
		in_valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d bytes and %0d result lines (%0d directed lines, rest random).",
			bytes_sent, sb.lines_checked, directed_lines);
		$display("Mismatches counted: %0d", sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
